// ===== rtl/lct_pkg.sv =====
// Shared types and constants of the LFU cache table.
package lct_pkg;

   // Read data returned on a get miss and on every put.
   localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

   // Request word held by the control unit and broadcast to every cell.
   typedef struct packed {
      logic        op;
      logic [31:0] key;
      logic [31:0] value;
   } cmd_type;

   // State change that every cell applies at the same clock edge.
   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_HIT,
      UPD_INSERT,
      UPD_EVICT
   } upd_kind_type;

   // Control flags that travel down the chain with the search wavefront.
   typedef struct packed {
      logic tok;
      logic has_hit;
      logic has_free;
      logic has_vic;
   } sweep_flags_type;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

// ===== rtl/lct_cell.sv =====
// One entry of the LFU cache table with its stage of the search chain.
module lct_cell #(
   parameter int  MAX_ENTRIES = 16,
   parameter int  COUNT_BITS  = 16,
   parameter int  CELL_IDX    = 0,
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int NV_W        = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lct_pkg::cmd_type         cmd,
   input  lct_pkg::upd_kind_type    upd_kind,
   input  logic [IDX_W-1:0]         upd_idx,
   input  logic [IDX_W-1:0]         upd_rank,
   input  lct_pkg::sweep_flags_type flags_in,
   input  logic [IDX_W-1:0]         hit_idx_in,
   input  logic [IDX_W-1:0]         hit_rank_in,
   input  logic [31:0]              hit_value_in,
   input  logic [IDX_W-1:0]         free_idx_in,
   input  logic [NV_W-1:0]          nv_in,
   input  logic [IDX_W-1:0]         vic_idx_in,
   input  logic [COUNT_BITS-1:0]    vic_count_in,
   input  logic [IDX_W-1:0]         vic_rank_in,
   output lct_pkg::sweep_flags_type flags_out,
   output logic [IDX_W-1:0]         hit_idx_out,
   output logic [IDX_W-1:0]         hit_rank_out,
   output logic [31:0]              hit_value_out,
   output logic [IDX_W-1:0]         free_idx_out,
   output logic [NV_W-1:0]          nv_out,
   output logic [IDX_W-1:0]         vic_idx_out,
   output logic [COUNT_BITS-1:0]    vic_count_out,
   output logic [IDX_W-1:0]         vic_rank_out
);
   import lct_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                  valid_ff;
   logic [31:0]           key_ff;
   logic [31:0]           value_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [IDX_W-1:0]      rank_ff;

   sweep_flags_type       flags_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [IDX_W-1:0]      hit_rank_ff;
   logic [31:0]           hit_value_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [NV_W-1:0]       nv_ff;
   logic [IDX_W-1:0]      vic_idx_ff;
   logic [COUNT_BITS-1:0] vic_count_ff;
   logic [IDX_W-1:0]      vic_rank_ff;

   logic take_hit;
   logic take_free;
   logic take_vic;
   logic is_target;
   logic ages;

   always_comb begin
      take_hit  = valid_ff && (key_ff == cmd.key) && !flags_in.has_hit;
      take_free = !valid_ff && !flags_in.has_free;
      take_vic  = valid_ff && (!flags_in.has_vic || (count_ff < vic_count_in) ||
                  ((count_ff == vic_count_in) && (rank_ff > vic_rank_in)));
      is_target = (upd_idx == MY_IDX);
      ages      = valid_ff && ((upd_kind == UPD_INSERT) || (rank_ff < upd_rank));
   end

   // Search stage: fold this entry into the wavefront coming from the left.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff.tok <= flags_in.tok;
         if (flags_in.tok) begin
            flags_ff.has_hit  <= flags_in.has_hit || take_hit;
            flags_ff.has_free <= flags_in.has_free || take_free;
            flags_ff.has_vic  <= flags_in.has_vic || take_vic;
         end
      end
      if (flags_in.tok) begin
         hit_idx_ff   <= take_hit ? MY_IDX : hit_idx_in;
         hit_rank_ff  <= take_hit ? rank_ff : hit_rank_in;
         hit_value_ff <= take_hit ? value_ff : hit_value_in;
         free_idx_ff  <= take_free ? MY_IDX : free_idx_in;
         nv_ff        <= nv_in + NV_W'(valid_ff);
         vic_idx_ff   <= take_vic ? MY_IDX : vic_idx_in;
         vic_count_ff <= take_vic ? count_ff : vic_count_in;
         vic_rank_ff  <= take_vic ? rank_ff : vic_rank_in;
      end
   end

   // Entry state: the targeted entry becomes most recent, younger ones age.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (is_target && ((upd_kind == UPD_INSERT) || (upd_kind == UPD_EVICT))) begin
         valid_ff <= 1'b1;
      end
      case (upd_kind)
         UPD_NONE: begin
         end
         UPD_HIT: begin
            if (is_target) begin
               if (cmd.op == OP_PUT) begin
                  value_ff <= cmd.value;
               end
               if (count_ff != {COUNT_BITS{1'b1}}) begin
                  count_ff <= count_ff + 1'b1;
               end
               rank_ff <= '0;
            end else if (ages) begin
               rank_ff <= rank_ff + 1'b1;
            end
         end
         default: begin
            if (is_target) begin
               key_ff   <= cmd.key;
               value_ff <= cmd.value;
               count_ff <= COUNT_BITS'(1);
               rank_ff  <= '0;
            end else if (ages) begin
               rank_ff <= rank_ff + 1'b1;
            end
         end
      endcase
   end

   assign flags_out     = flags_ff;
   assign hit_idx_out   = hit_idx_ff;
   assign hit_rank_out  = hit_rank_ff;
   assign hit_value_out = hit_value_ff;
   assign free_idx_out  = free_idx_ff;
   assign nv_out        = nv_ff;
   assign vic_idx_out   = vic_idx_ff;
   assign vic_count_out = vic_count_ff;
   assign vic_rank_out  = vic_rank_ff;

endmodule

// ===== rtl/lfu_cache_table.sv =====
// Top level of the LFU cache table: control unit and the chain of entry cells.
//
// Usage. A request word (req_opcode, req_lookup_key, req_write_value) enters on the
// req_ channel; opcode 0 is a get, opcode 1 is a put. Each request yields exactly
// one response word on the rsp_ channel: rsp_hit, rsp_read_value (the stored value
// on a get hit, all ones otherwise) and rsp_evicted. The csr_ channel writes the
// capacity register; it is always ready and should only be written while idle.
//
// Timing. A request is taken only while the control unit is idle. A search token
// then walks the chain of MAX_ENTRIES cells, one cell per cycle, gathering the hit,
// the first free slot, the entry count and the eviction victim. When the token
// leaves the last cell, the control unit waits in S_RESP for a free output
// register, loads the response word and returns to idle to take the next request.
//
// Reset clears all valid bits and sets the capacity to 16. A response word that the
// receiver does not take waits in the output register; the next request may still
// be accepted and searched, and its result is held back until the output is free.
module lfu_cache_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic signed [31:0] req_lookup_key,
   input  logic signed [31:0] req_write_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_evicted,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_capacity
);
   import lct_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NV_W  = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_RESP
   } state_type;

   state_type        state_ff;
   logic [4:0]       cap_ff;
   cmd_type          cmd_ff;
   logic             start_ff;
   upd_kind_type     upd_kind_ff;
   logic [IDX_W-1:0] upd_idx_ff;
   logic [IDX_W-1:0] upd_rank_ff;
   logic             rsp_valid_ff;
   logic             rsp_hit_ff;
   logic [31:0]      rsp_value_ff;
   logic             rsp_evicted_ff;

   // Links between cells; link 0 is the chain head, the last link feeds back here.
   sweep_flags_type       flags_l     [MAX_ENTRIES+1];
   logic [IDX_W-1:0]      hit_idx_l   [MAX_ENTRIES+1];
   logic [IDX_W-1:0]      hit_rank_l  [MAX_ENTRIES+1];
   logic [31:0]           hit_value_l [MAX_ENTRIES+1];
   logic [IDX_W-1:0]      free_idx_l  [MAX_ENTRIES+1];
   logic [NV_W-1:0]       nv_l        [MAX_ENTRIES+1];
   logic [IDX_W-1:0]      vic_idx_l   [MAX_ENTRIES+1];
   logic [COUNT_BITS-1:0] vic_count_l [MAX_ENTRIES+1];
   logic [IDX_W-1:0]      vic_rank_l  [MAX_ENTRIES+1];

   // The search token enters with every gathered result still empty.
   always_comb begin
      flags_l[0]          = '0;
      flags_l[0].tok      = start_ff;
      hit_idx_l[0]        = '0;
      hit_rank_l[0]       = '0;
      hit_value_l[0]      = '0;
      free_idx_l[0]       = '0;
      nv_l[0]             = '0;
      vic_idx_l[0]        = '0;
      vic_count_l[0]      = '0;
      vic_rank_l[0]       = '0;
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      lct_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .COUNT_BITS  (COUNT_BITS),
         .CELL_IDX    (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd_ff),
         .upd_kind      (upd_kind_ff),
         .upd_idx       (upd_idx_ff),
         .upd_rank      (upd_rank_ff),
         .flags_in      (flags_l[g]),
         .hit_idx_in    (hit_idx_l[g]),
         .hit_rank_in   (hit_rank_l[g]),
         .hit_value_in  (hit_value_l[g]),
         .free_idx_in   (free_idx_l[g]),
         .nv_in         (nv_l[g]),
         .vic_idx_in    (vic_idx_l[g]),
         .vic_count_in  (vic_count_l[g]),
         .vic_rank_in   (vic_rank_l[g]),
         .flags_out     (flags_l[g+1]),
         .hit_idx_out   (hit_idx_l[g+1]),
         .hit_rank_out  (hit_rank_l[g+1]),
         .hit_value_out (hit_value_l[g+1]),
         .free_idx_out  (free_idx_l[g+1]),
         .nv_out        (nv_l[g+1]),
         .vic_idx_out   (vic_idx_l[g+1]),
         .vic_count_out (vic_count_l[g+1]),
         .vic_rank_out  (vic_rank_l[g+1])
      );
   end

   sweep_flags_type  fin;
   logic [31:0]      cap_eff;
   logic             room;
   logic             out_free;
   upd_kind_type     dec_kind;
   logic [IDX_W-1:0] dec_idx;
   logic [IDX_W-1:0] dec_rank;
   logic             dec_hit;
   logic [31:0]      dec_value;
   logic             dec_evicted;

   // Decision from the gathered search results; the last link holds them steady.
   always_comb begin
      fin      = flags_l[MAX_ENTRIES];
      cap_eff  = (32'(cap_ff) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(cap_ff);
      room     = (32'(nv_l[MAX_ENTRIES]) < cap_eff) && fin.has_free;
      out_free = !rsp_valid_ff || rsp_ready;

      dec_kind    = UPD_NONE;
      dec_idx     = '0;
      dec_rank    = '0;
      dec_hit     = 1'b0;
      dec_value   = READ_MISS;
      dec_evicted = 1'b0;
      if (cap_ff == 5'd0) begin
         // A zero capacity answers every request as a miss and stores nothing.
      end else if (fin.has_hit) begin
         dec_kind  = UPD_HIT;
         dec_idx   = hit_idx_l[MAX_ENTRIES];
         dec_rank  = hit_rank_l[MAX_ENTRIES];
         dec_hit   = 1'b1;
         if (cmd_ff.op == OP_GET) begin
            dec_value = hit_value_l[MAX_ENTRIES];
         end
      end else if (cmd_ff.op == OP_PUT) begin
         if (room) begin
            dec_kind = UPD_INSERT;
            dec_idx  = free_idx_l[MAX_ENTRIES];
         end else begin
            // The victim has the lowest count and, among those, the oldest touch.
            dec_kind    = UPD_EVICT;
            dec_idx     = vic_idx_l[MAX_ENTRIES];
            dec_rank    = vic_rank_l[MAX_ENTRIES];
            dec_evicted = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= 5'd16;
         start_ff     <= 1'b0;
         upd_kind_ff  <= UPD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff    <= 1'b0;
         upd_kind_ff <= UPD_NONE;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  start_ff <= 1'b1;
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               if (fin.tok) begin
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  upd_kind_ff  <= dec_kind;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff.op    <= req_opcode;
         cmd_ff.key   <= req_lookup_key;
         cmd_ff.value <= req_write_value;
      end
      if (state_ff == S_RESP && out_free) begin
         upd_idx_ff     <= dec_idx;
         upd_rank_ff    <= dec_rank;
         rsp_hit_ff     <= dec_hit;
         rsp_value_ff   <= dec_value;
         rsp_evicted_ff <= dec_evicted;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule
